// ===== src/cpl_pkg.sv =====
package cpl_pkg;

    localparam int MAX_PAGES_DEF  = 4096;
    localparam int SLOT_BYTES_DEF = 8;

    localparam int PAGE_W   = 12;
    localparam int CHUNK_W  = 13;
    localparam int BASE_W   = 16;
    localparam int OFFS_W   = 17;
    localparam int KIND_W   = 2;
    localparam int ENTRY_W  = KIND_W + PAGE_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // divider: 14-bit dividend, 13-bit divisor, one quotient bit a step
    localparam int DIV_W    = CHUNK_W + 1;
    localparam int DCNT_W   = $clog2(DIV_W + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_PAGES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BASE   = 2'd3;

    // link kinds
    localparam logic [KIND_W-1:0] KIND_PAGE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NULL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RSVD  = 2'd3;

    // page states
    localparam logic [1:0] PST_META  = 2'd0;
    localparam logic [1:0] PST_FLI   = 2'd1;
    localparam logic [1:0] PST_FREE  = 2'd2;
    localparam logic [1:0] PST_ALLOC = 2'd3;

    // fault codes
    localparam logic [1:0] FLT_OK      = 2'd0;
    localparam logic [1:0] FLT_NONDATA = 2'd1;
    localparam logic [1:0] FLT_SETUP   = 2'd2;

    localparam logic [ENTRY_W-1:0] NULL_ENTRY = {KIND_NULL, {PAGE_W{1'b0}}};

    typedef logic [3:0] step_t;

    typedef enum logic [3:0] {
        OP_NOP       = 4'd0,
        OP_CLEAR     = 4'd1,
        OP_LATCH     = 4'd2,
        OP_CLASSIFY  = 4'd3,
        OP_LOAD_FLI  = 4'd4,
        OP_DIV_STEP  = 4'd5,
        OP_SAVE_FLI  = 4'd6,
        OP_LOAD_PN   = 4'd7,
        OP_SAVE_PN   = 4'd8,
        OP_LOAD_DATA = 4'd9,
        OP_LOCATE    = 4'd10,
        OP_STORE     = 4'd11,
        OP_FINAL     = 4'd12,
        OP_EMIT      = 4'd13
    } uop_t;

    typedef enum logic [2:0] {
        C_NEVER     = 3'd0,
        C_ALWAYS    = 3'd1,
        C_CLR_MORE  = 3'd2,
        C_NO_START  = 3'd3,
        C_EARLY     = 3'd4,
        C_FLI_CLEAN = 3'd5,
        C_DIV_MORE  = 3'd6,
        C_PN_IS_FLI = 3'd7
    } cond_t;

    typedef struct packed {
        uop_t  op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    localparam step_t S_CLEAR     = 4'd0;
    localparam step_t S_IDLE      = 4'd1;
    localparam step_t S_CHECK     = 4'd2;
    localparam step_t S_FLI_CHK   = 4'd3;
    localparam step_t S_FLI_LOAD  = 4'd4;
    localparam step_t S_FLI_DIV   = 4'd5;
    localparam step_t S_FLI_SAVE  = 4'd6;
    localparam step_t S_PN_LOAD   = 4'd7;
    localparam step_t S_PN_DIV    = 4'd8;
    localparam step_t S_PN_SAVE   = 4'd9;
    localparam step_t S_DATA_LOAD = 4'd10;
    localparam step_t S_DATA_DIV  = 4'd11;
    localparam step_t S_LOCATE    = 4'd12;
    localparam step_t S_STORE     = 4'd13;
    localparam step_t S_FINAL     = 4'd14;
    localparam step_t S_EMIT      = 4'd15;

    // microprogram: jump to target when cond holds, else fall through
    function automatic ctrl_word_t ucode_rom(input step_t s);
        ctrl_word_t w;
        case (s)
            S_CLEAR:     w = '{OP_CLEAR,     C_CLR_MORE,  S_CLEAR};
            S_IDLE:      w = '{OP_LATCH,     C_NO_START,  S_IDLE};
            S_CHECK:     w = '{OP_CLASSIFY,  C_EARLY,     S_EMIT};
            S_FLI_CHK:   w = '{OP_NOP,       C_FLI_CLEAN, S_PN_LOAD};
            S_FLI_LOAD:  w = '{OP_LOAD_FLI,  C_NEVER,     S_CLEAR};
            S_FLI_DIV:   w = '{OP_DIV_STEP,  C_DIV_MORE,  S_FLI_DIV};
            S_FLI_SAVE:  w = '{OP_SAVE_FLI,  C_NEVER,     S_CLEAR};
            S_PN_LOAD:   w = '{OP_LOAD_PN,   C_NEVER,     S_CLEAR};
            S_PN_DIV:    w = '{OP_DIV_STEP,  C_DIV_MORE,  S_PN_DIV};
            S_PN_SAVE:   w = '{OP_SAVE_PN,   C_PN_IS_FLI, S_EMIT};
            S_DATA_LOAD: w = '{OP_LOAD_DATA, C_NEVER,     S_CLEAR};
            S_DATA_DIV:  w = '{OP_DIV_STEP,  C_DIV_MORE,  S_DATA_DIV};
            S_LOCATE:    w = '{OP_LOCATE,    C_NEVER,     S_CLEAR};
            S_STORE:     w = '{OP_STORE,     C_NEVER,     S_CLEAR};
            S_FINAL:     w = '{OP_FINAL,     C_NEVER,     S_CLEAR};
            S_EMIT:      w = '{OP_EMIT,      C_ALWAYS,    S_IDLE};
            default:     w = '{OP_NOP,       C_ALWAYS,    S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== src/chunk_page_locator_top.sv =====
// a data page is answered after a page divide and a slot divide; a changed chunk_pages
//   or slots_per_fli_page forces the fli count to be redone first with one more divide
// one request at a time, busy until done; every divide uses the shared 14-step divider
// meta, out-of-range and unset-size requests answer straight after the check, fli pages after the page divide
// after reset a clearing pass nulls every link store entry (busy high)
// done is a one-cycle strobe; the receiver cannot stall it
module chunk_page_locator_top #(
    parameter int MAX_PAGES  = cpl_pkg::MAX_PAGES_DEF,
    parameter int SLOT_BYTES = cpl_pkg::SLOT_BYTES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // request side
    input  logic                               start,
    output logic                               busy,
    input  logic                               cmd,
    input  logic [cpl_pkg::PAGE_W-1:0]         page_id,
    input  logic [cpl_pkg::KIND_W-1:0]         link_kind,
    input  logic [cpl_pkg::PAGE_W-1:0]         link_page,
    // result side
    output logic                               done,
    output logic [1:0]                         page_state,
    output logic [1:0]                         fault,
    output logic [cpl_pkg::PAGE_W-1:0]         chunk_first_page,
    output logic [cpl_pkg::PAGE_W-1:0]         data_page_no,
    output logic [cpl_pkg::PAGE_W-1:0]         fli_page,
    output logic [cpl_pkg::OFFS_W-1:0]         slot_offset,
    output logic [cpl_pkg::KIND_W-1:0]         next_kind,
    output logic [cpl_pkg::PAGE_W-1:0]         next_page,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cpl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cpl_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import cpl_pkg::*;

    localparam int AW = $clog2(MAX_PAGES);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CHUNK_W-1:0] chunk_pages_reg;
    logic [CHUNK_W-1:0] slots_reg;
    logic [PAGE_W-1:0]  first_data_reg;
    logic [BASE_W-1:0]  slot_base_reg;
    logic               fli_dirty_reg;   // fli count must be redone before use
    logic [CHUNK_W-1:0] fli_reg;         // fli pages at the head of each chunk

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    step_t      upc_reg;
    step_t      upc_next;
    ctrl_word_t cw;
    logic       jump;

    // latched request
    logic               cmd_reg;
    logic [PAGE_W-1:0]  page_reg;
    logic [KIND_W-1:0]  lkind_reg;
    logic [PAGE_W-1:0]  lpage_reg;

    // shared divider
    logic [CHUNK_W-1:0] div_divisor_reg;
    logic [DIV_W-1:0]   div_q_reg;       // dividend shifts out, quotient shifts in
    logic [CHUNK_W-1:0] div_r_reg;
    logic [DCNT_W-1:0]  div_cnt_reg;
    logic [DIV_W-1:0]   div_shift;
    logic               div_fits;

    // working registers
    logic [PAGE_W-1:0]  pn_reg;
    logic [PAGE_W-1:0]  chunk_first_reg;
    logic [OFFS_W-1:0]  prod_reg;
    logic [AW-1:0]      clr_cnt_reg;

    // result registers
    logic [1:0]         res_state_reg;
    logic [1:0]         res_fault_reg;
    logic [PAGE_W-1:0]  res_chunk_first_reg;
    logic [PAGE_W-1:0]  res_data_no_reg;
    logic [PAGE_W-1:0]  res_fli_reg;
    logic [OFFS_W-1:0]  res_slot_reg;
    logic [KIND_W-1:0]  res_kind_reg;
    logic [PAGE_W-1:0]  res_next_reg;

    // link store
    logic [ENTRY_W-1:0] link_mem [MAX_PAGES];
    logic [ENTRY_W-1:0] rd_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_addr;
    logic [ENTRY_W-1:0] mem_wdata;

    // classification of the latched request
    logic               out_of_range;
    logic               is_meta;
    logic               size_unset;
    logic               early_exit;
    logic [PAGE_W-1:0]  rel_page;
    logic               pn_is_fli;
    logic [CHUNK_W-1:0] data_no;
    logic [KIND_W-1:0]  new_kind;
    logic [ENTRY_W-1:0] new_entry;
    logic [ENTRY_W-1:0] final_entry;
    logic [AW+PAGE_W-1:0] page_ext;
    logic [1:0]         write_fault;

    assign cw = ucode_rom(upc_reg);

    assign out_of_range = 32'(page_reg) >= 32'(MAX_PAGES);
    assign is_meta      = page_reg < first_data_reg;
    assign size_unset   = (chunk_pages_reg == '0) || (slots_reg == '0);
    assign early_exit   = out_of_range || is_meta || size_unset;
    assign rel_page     = page_reg - first_data_reg;
    assign pn_is_fli    = div_r_reg < fli_reg;
    assign data_no      = CHUNK_W'(pn_reg) - fli_reg;
    assign write_fault  = cmd_reg ? FLT_NONDATA : FLT_OK;

    // unused kind code is stored as a null link; page only kept for page links
    assign new_kind  = (lkind_reg == KIND_RSVD) ? KIND_NULL : lkind_reg;
    assign new_entry = {new_kind, (new_kind == KIND_PAGE) ? lpage_reg : {PAGE_W{1'b0}}};
    // a write answers with the link just stored
    assign final_entry = cmd_reg ? new_entry : rd_reg;

    assign page_ext = {{AW{1'b0}}, page_reg};

    // one restoring divide step
    assign div_shift = {div_r_reg, div_q_reg[DIV_W-1]};
    assign div_fits  = div_shift >= {1'b0, div_divisor_reg};

    always_comb
    begin
        case (cw.cond)
            C_NEVER:     jump = 1'b0;
            C_ALWAYS:    jump = 1'b1;
            C_CLR_MORE:  jump = clr_cnt_reg != AW'(MAX_PAGES - 1);
            C_NO_START:  jump = !start;
            C_EARLY:     jump = early_exit;
            C_FLI_CLEAN: jump = !fli_dirty_reg;
            C_DIV_MORE:  jump = div_cnt_reg != DCNT_W'(1);
            C_PN_IS_FLI: jump = pn_is_fli;
            default:     jump = 1'b0;
        endcase
        upc_next = jump ? cw.target : step_t'(upc_reg + 4'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg     <= S_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            upc_reg <= upc_next;
            if (cw.op == OP_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // configuration port; fli count is redone lazily by the next data or fli page request
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_pages_reg <= '0;
            slots_reg       <= CHUNK_W'(1);
            first_data_reg  <= '0;
            slot_base_reg   <= '0;
            fli_dirty_reg   <= 1'b0;
            fli_reg         <= '0;
        end
        else
        begin
            if (cw.op == OP_SAVE_FLI)
            begin
                fli_reg       <= div_q_reg[CHUNK_W-1:0];
                fli_dirty_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CHUNK_PAGES:
                    begin
                        chunk_pages_reg <= cfg_data[CHUNK_W-1:0];
                        fli_dirty_reg   <= 1'b1;
                    end
                    CFG_SLOTS:
                    begin
                        slots_reg     <= cfg_data[CHUNK_W-1:0];
                        fli_dirty_reg <= 1'b1;
                    end
                    CFG_FIRST_DATA: first_data_reg <= cfg_data[PAGE_W-1:0];
                    CFG_SLOT_BASE:  slot_base_reg  <= cfg_data[BASE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath driven by the current control word
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (cw.op)
            OP_LATCH:
            begin
                if (start)
                begin
                    cmd_reg   <= cmd;
                    page_reg  <= page_id;
                    lkind_reg <= link_kind;
                    lpage_reg <= link_page;
                end
            end
            OP_CLASSIFY:
            begin
                res_chunk_first_reg <= '0;
                res_data_no_reg     <= '0;
                res_fli_reg         <= '0;
                res_slot_reg        <= '0;
                res_kind_reg        <= '0;
                res_next_reg        <= '0;
                res_state_reg       <= PST_META;
                if (out_of_range)
                begin
                    res_fault_reg <= FLT_SETUP;
                end
                else if (is_meta)
                begin
                    res_fault_reg <= write_fault;
                end
                else if (size_unset)
                begin
                    res_fault_reg <= FLT_SETUP;
                end
                else
                begin
                    res_fault_reg <= FLT_OK;
                end
            end
            OP_LOAD_FLI:
            begin
                // ceil(chunk_pages / slots)
                div_q_reg       <= DIV_W'(chunk_pages_reg) + DIV_W'(slots_reg) - DIV_W'(1);
                div_r_reg       <= '0;
                div_divisor_reg <= slots_reg;
                div_cnt_reg     <= DCNT_W'(DIV_W);
            end
            OP_LOAD_PN:
            begin
                div_q_reg       <= DIV_W'(rel_page);
                div_r_reg       <= '0;
                div_divisor_reg <= chunk_pages_reg;
                div_cnt_reg     <= DCNT_W'(DIV_W);
            end
            OP_DIV_STEP:
            begin
                div_q_reg   <= {div_q_reg[DIV_W-2:0], div_fits};
                div_r_reg   <= div_fits ? CHUNK_W'(div_shift - DIV_W'(div_divisor_reg))
                                        : div_shift[CHUNK_W-1:0];
                div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
            end
            OP_SAVE_PN:
            begin
                // remainder is at most rel_page, so it fits a page id
                pn_reg <= div_r_reg[PAGE_W-1:0];
                if (pn_is_fli)
                begin
                    res_state_reg <= PST_FLI;
                    res_fault_reg <= write_fault;
                end
            end
            OP_LOAD_DATA:
            begin
                chunk_first_reg <= page_reg - pn_reg;
                res_data_no_reg <= data_no[PAGE_W-1:0];
                div_q_reg       <= DIV_W'(data_no);
                div_r_reg       <= '0;
                div_divisor_reg <= slots_reg;
                div_cnt_reg     <= DCNT_W'(DIV_W);
            end
            OP_LOCATE:
            begin
                res_chunk_first_reg <= chunk_first_reg;
                res_fli_reg         <= chunk_first_reg + div_q_reg[PAGE_W-1:0];
                prod_reg            <= OFFS_W'(div_r_reg) * OFFS_W'(SLOT_BYTES);
            end
            OP_FINAL:
            begin
                res_slot_reg  <= OFFS_W'(slot_base_reg) + prod_reg;
                res_kind_reg  <= final_entry[ENTRY_W-1:PAGE_W];
                res_next_reg  <= final_entry[PAGE_W-1:0];
                res_state_reg <= (final_entry[ENTRY_W-1:PAGE_W] == KIND_ALLOC) ? PST_ALLOC
                                                                              : PST_FREE;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // link store: clearing pass after reset, then one access per data-page request
    // ------------------------------------------------------------------
    assign mem_we    = (cw.op == OP_CLEAR) || ((cw.op == OP_STORE) && cmd_reg);
    assign mem_addr  = (cw.op == OP_CLEAR) ? clr_cnt_reg : page_ext[AW-1:0];
    assign mem_wdata = (cw.op == OP_CLEAR) ? NULL_ENTRY : new_entry;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_addr] <= mem_wdata;
        end
        rd_reg <= link_mem[mem_addr];
    end

    // ------------------------------------------------------------------
    // ports
    // ------------------------------------------------------------------
    assign busy             = upc_reg != S_IDLE;
    assign done             = upc_reg == S_EMIT;
    assign page_state       = res_state_reg;
    assign fault            = res_fault_reg;
    assign chunk_first_page = res_chunk_first_reg;
    assign data_page_no     = res_data_no_reg;
    assign fli_page         = res_fli_reg;
    assign slot_offset      = res_slot_reg;
    assign next_kind        = res_kind_reg;
    assign next_page        = res_next_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("sequencer did not return to idle after done");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cw.op == OP_DIV_STEP) |-> (div_divisor_reg != '0))
        else $error("divide step with zero divisor");

    a_store_only_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && (cw.op != OP_CLEAR)) |-> (cmd_reg && !early_exit))
        else $error("link store written for a non-data request");

    a_fault_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (fault != FLT_OK)) |->
            ((chunk_first_page == '0) && (slot_offset == '0) && (next_kind == '0)))
        else $error("faulted result carries data page fields");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import cpl_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 9;
    // covers the link store clearing pass after reset plus the longest gap and latency
    localparam int STALL_LIMIT    = 20000;
    localparam int SETTLE_CYCLES  = 60;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_REQUESTS = 100;

    // one expected answer of the locator
    typedef struct {
        logic [1:0]         state;
        logic [1:0]         fault;
        logic [PAGE_W-1:0]  chunk_first;
        logic [PAGE_W-1:0]  data_no;
        logic [PAGE_W-1:0]  fli;
        logic [OFFS_W-1:0]  slot_off;
        logic [KIND_W-1:0]  nkind;
        logic [PAGE_W-1:0]  npage;
    } page_location_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic                   cmd;
    logic [PAGE_W-1:0]      page_id;
    logic [KIND_W-1:0]      link_kind;
    logic [PAGE_W-1:0]      link_page;
    logic                   done;
    logic [1:0]             page_state;
    logic [1:0]             fault;
    logic [PAGE_W-1:0]      chunk_first_page;
    logic [PAGE_W-1:0]      data_page_no;
    logic [PAGE_W-1:0]      fli_page;
    logic [OFFS_W-1:0]      slot_offset;
    logic [KIND_W-1:0]      next_kind;
    logic [PAGE_W-1:0]      next_page;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // shadow copy of the locator state
    logic [ENTRY_W-1:0]     link_mem [MAX_PAGES_DEF];
    logic [CHUNK_W-1:0]     chunk_cfg;
    logic [CHUNK_W-1:0]     slots_cfg;
    logic [CHUNK_W-1:0]     fli_cfg;
    logic [PAGE_W-1:0]      first_cfg;
    logic [BASE_W-1:0]      base_cfg;

    page_location_t         expected_locations[$];
    logic [PAGE_W-1:0]      written_pages[$];

    bit                     sender_pauses;
    int                     mismatches;
    int                     requests_sent;
    int                     link_writes;
    int                     layouts;
    int                     cfg_writes;
    int                     faulted_results;
    int                     state_count [4];
    int unsigned            stall_cycles;

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    chunk_page_locator_top DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .cmd              (cmd),
        .page_id          (page_id),
        .link_kind        (link_kind),
        .link_page        (link_page),
        .done             (done),
        .page_state       (page_state),
        .fault            (fault),
        .chunk_first_page (chunk_first_page),
        .data_page_no     (data_page_no),
        .fli_page         (fli_page),
        .slot_offset      (slot_offset),
        .next_kind        (next_kind),
        .next_page        (next_page),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // register write; the fli page count follows both size registers
    function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_CHUNK_PAGES: chunk_cfg = val[CHUNK_W-1:0];
            CFG_SLOTS:       slots_cfg = val[CHUNK_W-1:0];
            CFG_FIRST_DATA:  first_cfg = val[PAGE_W-1:0];
            CFG_SLOT_BASE:   base_cfg  = val[BASE_W-1:0];
            default:         ;
        endcase
        if (slots_cfg == '0)
            fli_cfg = '0;
        else
            fli_cfg = CHUNK_W'((int'(chunk_cfg) + int'(slots_cfg) - 1) / int'(slots_cfg));
    endfunction

    // classify one page and, for a data page, locate its slot; a link write
    // updates the shadow store before the answer is formed
    function automatic page_location_t locate_page(logic c, logic [PAGE_W-1:0] pg,
                                                   logic [KIND_W-1:0] lk,
                                                   logic [PAGE_W-1:0] lp);
        page_location_t     loc;
        int unsigned        rel;
        int unsigned        pn;
        int unsigned        dn;
        int unsigned        base_pg;
        logic [KIND_W-1:0]  kind;
        logic [PAGE_W-1:0]  target;
        logic [ENTRY_W-1:0] entry;
        loc = '{default: '0};
        if (pg < first_cfg)
        begin
            loc.state = PST_META;
            loc.fault = c ? FLT_NONDATA : FLT_OK;
            return loc;
        end
        if (chunk_cfg == '0 || slots_cfg == '0)
        begin
            loc.fault = FLT_SETUP;
            return loc;
        end
        rel = int'(pg) - int'(first_cfg);
        pn  = rel % int'(chunk_cfg);
        if (pn < int'(fli_cfg))
        begin
            loc.state = PST_FLI;
            loc.fault = c ? FLT_NONDATA : FLT_OK;
            return loc;
        end
        base_pg = int'(pg) - pn;
        dn      = pn - int'(fli_cfg);
        if (c)
        begin
            // the unused kind is kept as a null link, only page links keep a target
            kind   = (lk == KIND_RSVD) ? KIND_NULL : lk;
            target = (kind == KIND_PAGE) ? lp : '0;
            link_mem[pg] = {kind, target};
        end
        entry = link_mem[pg];
        loc.state       = (entry[ENTRY_W-1:PAGE_W] == KIND_ALLOC) ? PST_ALLOC : PST_FREE;
        loc.fault       = FLT_OK;
        loc.chunk_first = PAGE_W'(base_pg);
        loc.data_no     = PAGE_W'(dn);
        loc.fli         = PAGE_W'(base_pg + dn / int'(slots_cfg));
        loc.slot_off    = OFFS_W'(int'(base_cfg) + (dn % int'(slots_cfg)) * SLOT_BYTES_DEF);
        loc.nkind       = entry[ENTRY_W-1:PAGE_W];
        loc.npage       = entry[PAGE_W-1:0];
        return loc;
    endfunction

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // every done strobe is matched against the oldest outstanding request
    always @(posedge clk)
    begin : result_check
        page_location_t want;
        if (done === 1'b1)
        begin
            if (fault != FLT_OK)
                faulted_results++;
            else
                state_count[page_state]++;
            if (expected_locations.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with no request outstanding, %s %0h fault %0h",
                         $time, "expected none actual state", page_state, fault);
            end
            else
            begin
                want = expected_locations.pop_front();
                compare_field("page_state", want.state, page_state);
                compare_field("fault", want.fault, fault);
                compare_field("chunk_first_page", want.chunk_first, chunk_first_page);
                compare_field("data_page_no", want.data_no, data_page_no);
                compare_field("fli_page", want.fli, fli_page);
                compare_field("slot_offset", want.slot_off, slot_offset);
                compare_field("next_kind", want.nkind, next_kind);
                compare_field("next_page", want.npage, next_page);
            end
        end
    end

    // watchdog: any request, result or register write counts as progress
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("chunk_page_locator_top test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    // hold one request on the port until the locator takes it
    task automatic send_request(input logic c, input logic [PAGE_W-1:0] pg,
                                input logic [KIND_W-1:0] lk, input logic [PAGE_W-1:0] lp);
        int gap;
        bit taken;
        gap = sender_pauses ? $urandom_range(0, 13) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start     <= 1'b1;
        cmd       <= c;
        page_id   <= pg;
        link_kind <= lk;
        link_page <= lp;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !busy;
        end
        expected_locations.push_back(locate_page(c, pg, lk, lp));
        requests_sent++;
        if (c)
            link_writes++;
    endtask

    // stop issuing and wait for every outstanding result
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (expected_locations.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        bit taken;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = cfg_ready;
        end
        apply_setting(idx, CFG_DATA_W'(val));
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // registers change only with nothing in flight
    task automatic set_layout(input int unsigned chunk, input int unsigned slots,
                              input int unsigned first, input int unsigned base);
        drain_results();
        write_register(CFG_CHUNK_PAGES, chunk);
        write_register(CFG_SLOTS, slots);
        write_register(CFG_FIRST_DATA, first);
        write_register(CFG_SLOT_BASE, base);
        layouts++;
    endtask

    // mostly pages in the first few chunks, some anywhere, some already linked
    task automatic random_request();
        logic               c;
        logic [PAGE_W-1:0]  pg;
        logic [KIND_W-1:0]  lk;
        int unsigned        span;
        int unsigned        pick;
        pick = $urandom_range(0, 99);
        c    = ($urandom_range(0, 99) < 45);
        span = int'(chunk_cfg) * 3 + 16;
        if (span > MAX_PAGES_DEF - 1 - int'(first_cfg))
            span = MAX_PAGES_DEF - 1 - int'(first_cfg);
        if (pick < 15)
            pg = PAGE_W'($urandom_range(0, MAX_PAGES_DEF - 1));
        else if (pick < 40 && written_pages.size() > 0)
            pg = written_pages[$urandom_range(0, written_pages.size() - 1)];
        else
            pg = PAGE_W'(int'(first_cfg) + $urandom_range(0, span));
        lk = ($urandom_range(0, 9) == 0) ? KIND_RSVD : KIND_W'($urandom_range(0, 2));
        if (c)
        begin
            written_pages.push_back(pg);
            if (written_pages.size() > 32)
                void'(written_pages.pop_front());
        end
        send_request(c, pg, lk, PAGE_W'($urandom));
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // straight after reset the chunk size is unset; meta pages still resolve
    task automatic test_unset_chunk_size();
        send_request(1'b0, 12'd0, KIND_PAGE, 12'd0);
        send_request(1'b1, 12'd4095, KIND_PAGE, 12'd4095);
        drain_results();
        write_register(CFG_FIRST_DATA, 8);
        send_request(1'b0, 12'd3, KIND_NULL, 12'd0);
        send_request(1'b1, 12'd5, KIND_ALLOC, 12'd9);
    endtask

    // 16-page chunks with 4 fli pages each, data area from page 8
    task automatic test_page_classes();
        set_layout(16, 4, 8, 0);
        send_request(1'b0, 12'd0, KIND_PAGE, 12'd0);
        send_request(1'b1, 12'd7, KIND_PAGE, 12'd1);
        send_request(1'b0, 12'd8, KIND_PAGE, 12'd0);
        send_request(1'b1, 12'd11, KIND_ALLOC, 12'd0);
        send_request(1'b0, 12'd12, KIND_PAGE, 12'd0);
        send_request(1'b0, 12'd23, KIND_PAGE, 12'd0);
        send_request(1'b0, 12'd24, KIND_PAGE, 12'd0);
    endtask

    // each link kind, the reserved kind and a link pointing at a meta page
    task automatic test_link_kinds();
        send_request(1'b1, 12'd12, KIND_PAGE, 12'd4095);
        send_request(1'b1, 12'd13, KIND_ALLOC, 12'd123);
        send_request(1'b1, 12'd14, KIND_RSVD, 12'd77);
        send_request(1'b1, 12'd15, KIND_NULL, 12'd5);
        send_request(1'b0, 12'd13, KIND_PAGE, 12'd0);
        send_request(1'b0, 12'd14, KIND_PAGE, 12'd0);
        send_request(1'b1, 12'd12, KIND_PAGE, 12'd0);
    endtask

    // chunk and slot counts that span all 4096 pages, with the slot base at its top
    task automatic test_slot_area_limits();
        set_layout(4096, 4096, 0, 65535);
        send_request(1'b0, 12'd4095, KIND_PAGE, 12'd0);
        send_request(1'b1, 12'd1, KIND_ALLOC, 12'd4095);
        send_request(1'b0, 12'd0, KIND_PAGE, 12'd0);
    endtask

    // chunks made only of fli pages, and a data area starting at the last page
    task automatic test_degenerate_chunks();
        set_layout(4096, 1, 0, 0);
        send_request(1'b0, 12'd2048, KIND_PAGE, 12'd0);
        set_layout(1, 1, 0, 0);
        send_request(1'b1, 12'd4095, KIND_PAGE, 12'd2);
        set_layout(4095, 4095, 4095, 0);
        send_request(1'b0, 12'd4095, KIND_PAGE, 12'd0);
        send_request(1'b0, 12'd4094, KIND_PAGE, 12'd0);
    endtask

    // zero slots per fli page leaves every non-meta page unresolved
    task automatic test_zero_slots();
        set_layout(16, 0, 8, 0);
        send_request(1'b0, 12'd3, KIND_PAGE, 12'd0);
        send_request(1'b0, 12'd20, KIND_PAGE, 12'd0);
        send_request(1'b1, 12'd20, KIND_PAGE, 12'd20);
    endtask

    // random layouts, each followed by a burst of random requests
    task automatic test_random_traffic();
        int          phase;
        int          n;
        int unsigned pick;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                set_layout($urandom_range(1, 48), $urandom_range(1, 12),
                           $urandom_range(0, 64), $urandom_range(0, 65535));
            else if (pick < 9)
                set_layout($urandom_range(1, 4096), $urandom_range(1, 4096),
                           $urandom_range(0, 4095), $urandom_range(0, 65535));
            else
                set_layout($urandom_range(2000, 4096), $urandom_range(64, 4096),
                           $urandom_range(0, 512), $urandom_range(0, 65535));
            // every third phase runs back to back requests
            sender_pauses = (phase % 3) != 2;
            for (n = 0; n < PHASE_REQUESTS; n++)
                random_request();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = 1'b0;
        page_id   = '0;
        link_kind = KIND_PAGE;
        link_page = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_CHUNK_PAGES;
        cfg_data  = '0;
        sender_pauses = 1'b1;
        stall_cycles  = 0;
        for (int i = 0; i < MAX_PAGES_DEF; i++)
            link_mem[i] = NULL_ENTRY;
        chunk_cfg = '0;
        slots_cfg = CHUNK_W'(1);
        first_cfg = '0;
        base_cfg  = '0;
        fli_cfg   = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_unset_chunk_size();
        test_page_classes();
        test_link_kinds();
        test_slot_area_limits();
        test_degenerate_chunks();
        test_zero_slots();
        test_random_traffic();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_locations.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_locations.size());
            mismatches += expected_locations.size();
        end

        $display("covered %0d requests (%0d link writes) across %0d layouts, %0d %s",
                 requests_sent, link_writes, layouts, cfg_writes, "register writes");
        $display("answers seen: %0d meta, %0d fli, %0d free, %0d allocated, %0d faulted",
                 state_count[PST_META], state_count[PST_FLI], state_count[PST_FREE],
                 state_count[PST_ALLOC], faulted_results);
        if (mismatches == 0)
            $display("chunk_page_locator_top test passed");
        else
            $display("chunk_page_locator_top test failed");
        $finish;
    end

endmodule
